[rtl/two_sided_diffuse_shade_macros.svh]
// assertion helpers for the two-sided diffuse shader
`ifndef TWO_SIDED_DIFFUSE_SHADE_MACROS_SVH
`define TWO_SIDED_DIFFUSE_SHADE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TSDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsds: implication failed");
// next-cycle implication
`define TSDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsds: next-cycle check failed");
`else
`define TSDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tsds_pkg.sv]
`timescale 1ns / 1ps
package tsds_pkg;
    localparam int NORM_LAT = 42;
    localparam logic [1:0] CFG_RED   = 2'd0;
    localparam logic [1:0] CFG_GREEN = 2'd1;
    localparam logic [1:0] CFG_BLUE  = 2'd2;
    localparam logic [15:0] DIFFUSE_RST = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_vec;
endpackage

[rtl/tsds_in_if.sv]
`timescale 1ns / 1ps
interface tsds_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               normal_from_attribute;
    logic signed [15:0] in_dir_x;
    logic signed [15:0] in_dir_y;
    logic signed [15:0] in_dir_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    modport source (output valid, normal_x, normal_y, normal_z, normal_from_attribute,
                    in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y, out_dir_z,
                    input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, normal_from_attribute,
                  in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y, out_dir_z,
                  output ready);
endinterface

[rtl/tsds_out_if.sv]
`timescale 1ns / 1ps
interface tsds_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
    logic        degenerate;
    modport source (output valid, color_red, color_green, color_blue, degenerate,
                    input ready);
    modport sink (input valid, color_red, color_green, color_blue, degenerate,
                  output ready);
endinterface

[rtl/two_sided_diffuse_shade.sv]
`timescale 1ns / 1ps
// two-sided lambert diffuse shading, one sample per item
// input channel i_in: normal, incoming and outgoing direction (signed q2.14)
// and the attribute flag; output channel o_res: rgb (unsigned q0.16) and a
// degenerate flag. both channels are valid/ready, accepted when both high.
// config: i_cfg_we writes i_cfg_data to diffuse red/green/blue (index 0..2),
// other indexes are ignored; write only while the pipe is empty.
// path: from accept to result valid an item passes the normalizers (squares
// and sum, one-bit-per-stage square root, one-bit-per-stage division), then
// products, dot sums, color multiply and the output register.
// throughput: one item per cycle unless stalled; every stage is a register stage.
// reset: all valid bits clear, diffuse colors return to full white.
// stall: when the output register holds an unaccepted result the whole
// pipeline freezes and i_in.ready drops; nothing is lost or repeated.
`include "two_sided_diffuse_shade_macros.svh"
module two_sided_diffuse_shade
    import tsds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsds_in_if.sink     i_in,
    tsds_out_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    // diffuse color registers
    logic [15:0] r_diff [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff[0] <= DIFFUSE_RST;
            r_diff[1] <= DIFFUSE_RST;
            r_diff[2] <= DIFFUSE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED:   r_diff[0] <= i_cfg_data;
                CFG_GREEN: r_diff[1] <= i_cfg_data;
                CFG_BLUE:  r_diff[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the output register is empty or being drained
    logic r_o_vld;
    logic w_en;
    assign w_en       = !r_o_vld || o_res.ready;
    assign i_in.ready = w_en;

    t_vec w_n_raw, w_o_raw, w_i_raw, w_nn, w_on;
    logic w_nz, w_oz;
    assign w_n_raw = '{x: i_in.normal_x, y: i_in.normal_y, z: i_in.normal_z};
    assign w_o_raw = '{x: i_in.out_dir_x, y: i_in.out_dir_y, z: i_in.out_dir_z};
    assign w_i_raw = '{x: i_in.in_dir_x, y: i_in.in_dir_y, z: i_in.in_dir_z};

    tsds_norm u_norm_n (
        .i_clk (i_clk), .i_en (w_en), .i_vec (w_n_raw), .o_vec (w_nn), .o_zero (w_nz)
    );
    tsds_norm u_norm_o (
        .i_clk (i_clk), .i_en (w_en), .i_vec (w_o_raw), .o_vec (w_on), .o_zero (w_oz)
    );

    // side data rides alongside the normalizers
    logic r_dl_vld  [0:NORM_LAT-1];
    logic r_dl_attr [0:NORM_LAT-1];
    t_vec r_dl_n    [0:NORM_LAT-1];
    t_vec r_dl_i    [0:NORM_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NORM_LAT; k++) r_dl_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_dl_vld[0] <= i_in.valid;
            for (int k = 1; k < NORM_LAT; k++) r_dl_vld[k] <= r_dl_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_attr[0] <= i_in.normal_from_attribute;
            r_dl_n[0]    <= w_n_raw;
            r_dl_i[0]    <= w_i_raw;
            for (int k = 1; k < NORM_LAT; k++) begin
                r_dl_attr[k] <= r_dl_attr[k-1];
                r_dl_n[k]    <= r_dl_n[k-1];
                r_dl_i[k]    <= r_dl_i[k-1];
            end
        end
    end

    // dot product terms; geometric normal used as given
    t_vec w_nsel;
    assign w_nsel = r_dl_attr[NORM_LAT-1] ? w_nn : r_dl_n[NORM_LAT-1];

    logic               r_p_vld, r_p_deg;
    logic signed [31:0] r_p_in  [0:2];
    logic signed [31:0] r_p_out [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= r_dl_vld[NORM_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_deg    <= (r_dl_attr[NORM_LAT-1] && w_nz) || w_oz;
            r_p_in[0]  <= w_nsel.x * r_dl_i[NORM_LAT-1].x;
            r_p_in[1]  <= w_nsel.y * r_dl_i[NORM_LAT-1].y;
            r_p_in[2]  <= w_nsel.z * r_dl_i[NORM_LAT-1].z;
            r_p_out[0] <= w_nsel.x * w_on.x;
            r_p_out[1] <= w_nsel.y * w_on.y;
            r_p_out[2] <= w_nsel.z * w_on.z;
        end
    end

    // dot sums, q6.28
    logic               r_s_vld, r_s_deg;
    logic signed [33:0] r_s_din, r_s_dout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_en) begin
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_deg  <= r_p_deg;
            r_s_din  <= 34'(r_p_in[0]) + 34'(r_p_in[1]) + 34'(r_p_in[2]);
            r_s_dout <= 34'(r_p_out[0]) + 34'(r_p_out[1]) + 34'(r_p_out[2]);
        end
    end

    // side test and color multiply
    logic        w_opp;
    logic [33:0] w_mag_full;
    logic [31:0] w_mag;
    assign w_opp = (r_s_din[33] && !r_s_dout[33] && (r_s_dout != '0))
                || (r_s_dout[33] && !r_s_din[33] && (r_s_din != '0));
    assign w_mag_full = r_s_dout[33] ? 34'(-r_s_dout) : r_s_dout;
    assign w_mag      = w_mag_full[31:0];

    logic        r_c_vld, r_c_deg, r_c_blk;
    logic [47:0] r_c_prod [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_deg <= r_s_deg;
            r_c_blk <= r_s_deg || w_opp;
            for (int i = 0; i < 3; i++) r_c_prod[i] <= w_mag * r_diff[i];
        end
    end

    // saturate to q0.16 into the output register; degenerate or opposite-side items give black
    logic        r_o_deg;
    logic [15:0] r_o_col [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_deg <= r_c_deg;
            for (int i = 0; i < 3; i++) begin
                if (r_c_blk) begin
                    r_o_col[i] <= '0;
                end else if (r_c_prod[i][47:44] != 4'd0) begin
                    r_o_col[i] <= 16'hFFFF;
                end else begin
                    r_o_col[i] <= r_c_prod[i][43:28];
                end
            end
        end
    end

    assign o_res.valid       = r_o_vld;
    assign o_res.color_red   = r_o_col[0];
    assign o_res.color_green = r_o_col[1];
    assign o_res.color_blue  = r_o_col[2];
    assign o_res.degenerate  = r_o_deg;

    // a degenerate result is always black
    `TSDS_ASSERT_IMP(a_deg_black, i_clk, i_rst_n, r_o_vld && r_o_deg,
        r_o_col[0] == 16'd0 && r_o_col[1] == 16'd0 && r_o_col[2] == 16'd0)
    // a frozen pipe keeps its side data valid bit
    `TSDS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_en,
        r_dl_vld[NORM_LAT-1] == $past(r_dl_vld[NORM_LAT-1]))
    // a new result comes from the color stage
    `TSDS_ASSERT_IMP(a_res_src, i_clk, i_rst_n, $rose(r_o_vld), $past(r_c_vld))
endmodule

[rtl/tsds_norm.sv]
`timescale 1ns / 1ps
module tsds_norm
    import tsds_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_vec,
    output t_vec o_vec,
    output logic o_zero
);
    // squares
    logic [30:0] r_sq  [0:2];
    logic [15:0] r_m0  [0:2];
    logic        r_s0  [0:2];
    // root stages
    logic [25:0] r_sr_rem  [0:24];
    logic [23:0] r_sr_root [0:24];
    logic [47:0] r_sr_v    [0:24];
    logic [15:0] r_sr_mag  [0:24][0:2];
    logic        r_sr_sgn  [0:24][0:2];
    logic        r_sr_zero [0:24];
    // divide stages
    logic [24:0] r_dv_rem  [0:15][0:2];
    logic [14:0] r_dv_q    [0:15][0:2];
    logic [23:0] r_dv_len  [0:15];
    logic        r_dv_sgn  [0:15][0:2];
    logic        r_dv_zero [0:15];

    logic [15:0] w_c [0:2];
    assign w_c[0] = i_vec.x;
    assign w_c[1] = i_vec.y;
    assign w_c[2] = i_vec.z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m0[i] <= w_c[i][15] ? 16'(-w_c[i]) : w_c[i];
                r_s0[i] <= w_c[i][15];
                r_sq[i] <= 31'($signed(w_c[i]) * $signed(w_c[i]));
            end
        end
    end

    // sum of squares, loads the first root stage
    always_ff @(posedge i_clk) begin
        logic [31:0] v_sum;
        if (i_en) begin
            v_sum = 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
            r_sr_v[0]    <= {v_sum, 16'd0};
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
            r_sr_zero[0] <= (v_sum == 32'd0);
            for (int i = 0; i < 3; i++) begin
                r_sr_mag[0][i] <= r_m0[i];
                r_sr_sgn[0][i] <= r_s0[i];
            end
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < 24; k++) begin : g_root
        always_ff @(posedge i_clk) begin
            logic [27:0] v_br;
            logic [27:0] v_t;
            if (i_en) begin
                v_br = {r_sr_rem[k], r_sr_v[k][47:46]};
                v_t  = {2'b00, r_sr_root[k], 2'b01};
                if (v_br >= v_t) begin
                    r_sr_rem[k+1]  <= 26'(v_br - v_t);
                    r_sr_root[k+1] <= {r_sr_root[k][22:0], 1'b1};
                end else begin
                    r_sr_rem[k+1]  <= 26'(v_br);
                    r_sr_root[k+1] <= {r_sr_root[k][22:0], 1'b0};
                end
                r_sr_v[k+1]    <= {r_sr_v[k][45:0], 2'b00};
                r_sr_zero[k+1] <= r_sr_zero[k];
                for (int i = 0; i < 3; i++) begin
                    r_sr_mag[k+1][i] <= r_sr_mag[k][i];
                    r_sr_sgn[k+1][i] <= r_sr_sgn[k][i];
                end
            end
        end
    end

    // quotient fits in 15 bits, so the dividend starts at mag * 2^7
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_len[0]  <= r_sr_root[24];
            r_dv_zero[0] <= r_sr_zero[24];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= {2'b00, r_sr_mag[24][i], 7'd0};
                r_dv_q[0][i]   <= '0;
                r_dv_sgn[0][i] <= r_sr_sgn[24][i];
            end
        end
    end

    for (genvar j = 0; j < 15; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [25:0] v_sh;
            if (i_en) begin
                r_dv_len[j+1]  <= r_dv_len[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
                for (int i = 0; i < 3; i++) begin
                    v_sh = {r_dv_rem[j][i], 1'b0};
                    if (v_sh >= {2'b00, r_dv_len[j]}) begin
                        r_dv_rem[j+1][i] <= 25'(v_sh - {2'b00, r_dv_len[j]});
                        r_dv_q[j+1][i]   <= {r_dv_q[j][i][13:0], 1'b1};
                    end else begin
                        r_dv_rem[j+1][i] <= 25'(v_sh);
                        r_dv_q[j+1][i]   <= {r_dv_q[j][i][13:0], 1'b0};
                    end
                    r_dv_sgn[j+1][i] <= r_dv_sgn[j][i];
                end
            end
        end
    end

    assign o_vec.x = r_dv_sgn[15][0] ? -$signed({1'b0, r_dv_q[15][0]})
                                     : $signed({1'b0, r_dv_q[15][0]});
    assign o_vec.y = r_dv_sgn[15][1] ? -$signed({1'b0, r_dv_q[15][1]})
                                     : $signed({1'b0, r_dv_q[15][1]});
    assign o_vec.z = r_dv_sgn[15][2] ? -$signed({1'b0, r_dv_q[15][2]})
                                     : $signed({1'b0, r_dv_q[15][2]});
    assign o_zero  = r_dv_zero[15];
endmodule
